>>> hw/rtl/krp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// krp_pkg
// Types, codes and helpers shared by the keyed resource pool.
// ---------------------------------------------------------------------------
package krp_pkg;

  localparam int KEY_W    = 38;
  localparam int HANDLE_W = 4;
  localparam int HANDLES  = 16;
  localparam int STATUS_W = 3;
  localparam int REMOVE_W = 5;

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_SWEEP   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED    = 3'd0,
    ST_CREATED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_SWEPT     = 3'd5
  } status_t;

  typedef struct packed {
    func_t                func;
    logic [KEY_W-1:0]     key;
    logic [HANDLE_W-1:0]  handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    status_t              status;
    logic [REMOVE_W-1:0]  removed;
    logic                 busy;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [HANDLE_W-1:0]  handle;
    logic                 busy;
    logic                 recent;
  } entry_t;

  // lowest handle not held
  function automatic logic [HANDLE_W-1:0] first_free(input logic [HANDLES-1:0] held);
    logic [HANDLE_W-1:0] h;
    h = '0;
    for (int i = HANDLES - 1; i >= 0; i--) begin
      if (!held[i]) h = HANDLE_W'(i);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/krp_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// krp_req_if
// Request channel of the resource pool: valid, ready and request fields.
// ---------------------------------------------------------------------------
interface krp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] width;
  logic [15:0] height;
  logic        mode_2d;
  logic [4:0]  format;
  logic [3:0]  handle_in;

  modport source (output valid, func, width, height, mode_2d, format, handle_in,
                  input ready);
  modport sink (input valid, func, width, height, mode_2d, format, handle_in,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/krp_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// krp_rsp_if
// Response channel of the resource pool: valid, ready and result fields.
// ---------------------------------------------------------------------------
interface krp_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] handle_out;
  logic [2:0] status;
  logic [4:0] removed_count;
  logic       busy_at_sweep;

  modport source (output valid, handle_out, status, removed_count, busy_at_sweep,
                  input ready);
  modport sink (input valid, handle_out, status, removed_count, busy_at_sweep,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/krp_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// krp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module krp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/krp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// krp_ctrl
// Walks the entry list in the RAM, one entry per cycle, for acquire,
// release and sweep, and writes back matches, appends and compactions.
// ---------------------------------------------------------------------------
module krp_ctrl import krp_pkg::*; #(
  parameter int POOL_DEPTH = 16,
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int CW = $clog2(POOL_DEPTH + 1),
  localparam int EW = $bits(entry_t)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire req_t          req,
  output logic               idle,
  output rsp_t               res,
  output logic               res_valid,
  input  wire logic          res_take,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [EW-1:0]      ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [EW-1:0] ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH, S_DONE} state_t;

  state_t              state;
  req_t                req_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_ptr;
  logic [CW-1:0]       wr_ptr;
  logic [AW-1:0]       data_idx;
  logic                rd_vld;
  logic [HANDLES-1:0]  held;
  logic [REMOVE_W-1:0] removed;
  logic                busy_seen;

  entry_t              e;
  entry_t              wentry;
  logic                hit_acq;
  logic                hit_rel;
  logic                keep;
  logic                last;
  logic                full;
  logic [HANDLES-1:0]  held_next;
  logic [HANDLE_W-1:0] free_h;

  assign e         = entry_t'(ram_rdata);
  assign hit_acq   = !e.busy && (e.key == req_q.key);
  assign hit_rel   = e.handle == req_q.handle;
  assign keep      = e.busy || e.recent;
  assign last      = (CW'(data_idx) + CW'(1)) == count;
  assign held_next = held | (HANDLES'(1) << e.handle);
  assign free_h    = first_free(held);
  assign full      = (count == CW'(POOL_DEPTH)) || (&held);

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_DONE;
  assign ram_raddr = rd_ptr[AW-1:0];
  assign ram_wdata = EW'(wentry);

  always_comb begin
    ram_re = (state == S_WALK) && (rd_ptr < count) &&
             !(rd_vld && ((req_q.func == FUNC_ACQUIRE && hit_acq) ||
                          (req_q.func == FUNC_RELEASE && hit_rel)));
    ram_we    = 1'b0;
    ram_waddr = data_idx;
    wentry    = e;
    if (state == S_WALK && rd_vld) begin
      case (req_q.func)
        FUNC_ACQUIRE: begin
          ram_we        = hit_acq;
          wentry.busy   = 1'b1;
          wentry.recent = 1'b1;
        end
        FUNC_RELEASE: begin
          ram_we      = hit_rel;
          wentry.busy = 1'b0;
        end
        FUNC_SWEEP: begin
          ram_we        = keep;
          ram_waddr     = wr_ptr[AW-1:0];
          wentry.recent = e.busy && e.recent;
        end
        default: ram_we = 1'b0;
      endcase
    end else if (state == S_FINISH && req_q.func == FUNC_ACQUIRE && !full) begin
      ram_we    = 1'b1;
      ram_waddr = count[AW-1:0];
      wentry    = '{key: req_q.key, handle: free_h, busy: 1'b1, recent: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (start && req.func != FUNC_NONE) begin
            req_q     <= req;
            rd_ptr    <= '0;
            wr_ptr    <= '0;
            held      <= '0;
            removed   <= '0;
            busy_seen <= 1'b0;
            state     <= (count == '0) ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          if (ram_re) begin
            rd_ptr   <= rd_ptr + CW'(1);
            data_idx <= rd_ptr[AW-1:0];
          end
          rd_vld <= ram_re;
          if (rd_vld) begin
            case (req_q.func)
              FUNC_ACQUIRE: begin
                held <= held_next;
                if (hit_acq) begin
                  res    <= '{handle: e.handle, status: ST_REUSED, removed: '0, busy: 1'b0};
                  state  <= S_DONE;
                end else if (last) begin
                  state <= S_FINISH;
                end
              end
              FUNC_RELEASE: begin
                if (hit_rel) begin
                  res    <= '{handle: '0, status: ST_RELEASED, removed: '0, busy: 1'b0};
                  state  <= S_DONE;
                end else if (last) begin
                  state <= S_FINISH;
                end
              end
              FUNC_SWEEP: begin
                if (keep) wr_ptr <= wr_ptr + CW'(1);
                else if (removed != '1) removed <= removed + REMOVE_W'(1);
                if (e.busy) busy_seen <= 1'b1;
                if (last) state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_FINISH: begin
          case (req_q.func)
            FUNC_ACQUIRE: begin
              if (full) begin
                res <= '{handle: '0, status: ST_FULL, removed: '0, busy: 1'b0};
              end else begin
                res   <= '{handle: free_h, status: ST_CREATED, removed: '0, busy: 1'b0};
                count <= count + CW'(1);
              end
            end
            FUNC_RELEASE: begin
              res <= '{handle: '0, status: ST_NOT_FOUND, removed: '0, busy: 1'b0};
            end
            default: begin
              res   <= '{handle: '0, status: ST_SWEPT, removed: removed, busy: busy_seen};
              count <= wr_ptr;
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/keyed_resource_pool_with_aging.sv
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_resource_pool_with_aging
// Ordered pool of keyed entries with acquire, release and aging sweep.
// ---------------------------------------------------------------------------
// One transaction is handled at a time. The entry list lives in a RAM with a
// registered read and is walked one entry per cycle. A stall on the reply
// channel while the output register is still full holds the result in the
// controller. The next request is accepted as soon as the result has moved to
// the output register, even if the sink has not taken it yet. No clearing
// pass runs after reset; the pool starts empty.
module keyed_resource_pool_with_aging import krp_pkg::*; #(
  parameter int POOL_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  krp_req_if.sink   req,
  krp_rsp_if.source rsp
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int EW = $bits(entry_t);

  req_t          req_in;
  rsp_t          res;
  logic          idle;
  logic          res_valid;
  logic          res_take;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic          out_valid;
  rsp_t          out_q;

  assign req_in    = '{func: func_t'(req.func),
                       key: {req.width, req.height, req.mode_2d, req.format},
                       handle: req.handle_in};
  assign req.ready = idle;
  assign res_take  = !out_valid || rsp.ready;

  krp_ctrl #(.POOL_DEPTH(POOL_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && idle),
    .req       (req_in),
    .idle      (idle),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  krp_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
      out_q     <= res;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.handle_out    = out_q.handle;
  assign rsp.status        = out_q.status;
  assign rsp.removed_count = out_q.removed;
  assign rsp.busy_at_sweep = out_q.busy;

endmodule
`default_nettype wire

>>> tb/sv/keyed_resource_pool_with_aging_tb.sv
// ---------------------------------------------------------------------------
// keyed_resource_pool_with_aging_tb
// Self-checking bench for the keyed resource pool. A queue of requests is
// filled up front: a directed opening, then random phases of acquire,
// release and sweep over a small bank of keys. A driver feeds the request
// channel with random gaps and the reply channel stalls at random. Each
// accepted request but FUNC_NONE updates a shadow copy of the pool, whose
// reply is compared field by field with the next reply from the block.
// ---------------------------------------------------------------------------
module keyed_resource_pool_with_aging_tb;
  import krp_pkg::*;

  localparam int POOL_SLOTS   = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int BANK_SIZE    = 12;
  localparam int PHASE_LEN    = 150;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    func_t       func;
    logic [15:0] width;
    logic [15:0] height;
    logic        mode_2d;
    logic [4:0]  format;
    logic [3:0]  handle_in;
  } pool_req_t;

  logic clk;
  logic rst;

  krp_req_if req_ch ();
  krp_rsp_if rsp_ch ();

  keyed_resource_pool_with_aging #(
    .POOL_DEPTH(POOL_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the pool
  logic [KEY_W-1:0]    pool_key    [POOL_SLOTS];
  logic [HANDLE_W-1:0] pool_handle [POOL_SLOTS];
  bit                  pool_busy   [POOL_SLOTS];
  bit                  pool_recent [POOL_SLOTS];
  int                  pool_len;

  pool_req_t pending[$];
  rsp_t      replies_due[$];
  pool_req_t drv_req;
  pool_req_t seen_req;
  rsp_t      want;
  int        fails;
  int        cycle_count;
  bit        req_taken;
  int        idle_left;
  int        calm_left;
  int        stall_left;

  logic [15:0] bank_w [BANK_SIZE];
  logic [15:0] bank_h [BANK_SIZE];
  logic        bank_m [BANK_SIZE];
  logic [4:0]  bank_f [BANK_SIZE];

  always #5 clk = ~clk;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic rsp_t pool_apply(input pool_req_t item);
    rsp_t                reply;
    logic [KEY_W-1:0]    key;
    logic [HANDLES-1:0]  held;
    logic [HANDLE_W-1:0] fresh;
    bit                  found;
    bit                  in_use;
    int                  wr;
    int                  dropped;
    reply = '{handle: '0, status: ST_REUSED, removed: '0, busy: 1'b0};
    key = {item.width, item.height, item.mode_2d, item.format};
    case (item.func)
      FUNC_ACQUIRE: begin
        for (int i = 0; i < pool_len; i++) begin
          if (!pool_busy[i] && pool_key[i] == key) begin
            pool_busy[i]   = 1'b1;
            pool_recent[i] = 1'b1;
            reply.handle   = pool_handle[i];
            return reply;
          end
        end
        held = '0;
        for (int i = 0; i < pool_len; i++) held[pool_handle[i]] = 1'b1;
        if (pool_len >= POOL_SLOTS || &held) begin
          reply.status = ST_FULL;
          return reply;
        end
        found = 1'b0;
        fresh = '0;
        for (int h = 0; h < HANDLES; h++) begin
          if (!found && !held[h]) begin
            fresh = HANDLE_W'(h);
            found = 1'b1;
          end
        end
        pool_key[pool_len]    = key;
        pool_handle[pool_len] = fresh;
        pool_busy[pool_len]   = 1'b1;
        pool_recent[pool_len] = 1'b1;
        pool_len++;
        reply.handle = fresh;
        reply.status = ST_CREATED;
      end
      FUNC_RELEASE: begin
        reply.status = ST_NOT_FOUND;
        for (int i = 0; i < pool_len; i++) begin
          if (pool_handle[i] == item.handle_in) begin
            pool_busy[i] = 1'b0;
            reply.status = ST_RELEASED;
            return reply;
          end
        end
      end
      FUNC_SWEEP: begin
        wr      = 0;
        dropped = 0;
        in_use  = 1'b0;
        for (int rd = 0; rd < pool_len; rd++) begin
          if (pool_busy[rd]) begin
            in_use = 1'b1;
          end else if (!pool_recent[rd]) begin
            dropped++;
            continue;
          end else begin
            pool_recent[rd] = 1'b0;
          end
          pool_key[wr]    = pool_key[rd];
          pool_handle[wr] = pool_handle[rd];
          pool_busy[wr]   = pool_busy[rd];
          pool_recent[wr] = pool_recent[rd];
          wr++;
        end
        pool_len      = wr;
        reply.status  = ST_SWEPT;
        reply.removed = REMOVE_W'(dropped > 31 ? 31 : dropped);
        reply.busy    = in_use;
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic queue_req(input func_t f, input logic [15:0] w, input logic [15:0] h,
                           input logic m, input logic [4:0] fm, input logic [3:0] hd);
    pool_req_t item;
    item.func      = f;
    item.width     = w;
    item.height    = h;
    item.mode_2d   = m;
    item.format    = fm;
    item.handle_in = hd;
    pending.insert(pending.size(), item);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      idle_left    <= 0;
      calm_left    <= 0;
    end else if (req_ch.valid && !req_taken) begin
      // hold until taken
    end else if (idle_left > 0) begin
      req_ch.valid <= 1'b0;
      idle_left    <= idle_left - 1;
    end else if (pending.size() != 0) begin
      drv_req = pending.pop_front();
      req_ch.valid     <= 1'b1;
      req_ch.func      <= drv_req.func;
      req_ch.width     <= drv_req.width;
      req_ch.height    <= drv_req.height;
      req_ch.mode_2d   <= drv_req.mode_2d;
      req_ch.format    <= drv_req.format;
      req_ch.handle_in <= drv_req.handle_in;
      if (calm_left > 0) begin
        idle_left <= 0;
        calm_left <= calm_left - 1;
      end else begin
        idle_left <= idle_span();
        if ($urandom_range(0, 19) == 0) calm_left <= $urandom_range(10, 40);
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // reply back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_span();
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, handle_out %0d status %0d removed %0d busy %0d",
                   $time, rsp_ch.handle_out, rsp_ch.status, rsp_ch.removed_count,
                   rsp_ch.busy_at_sweep);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_ch.handle_out !== want.handle) begin
            $display("%0t: handle_out expected %0d actual %0d",
                     $time, want.handle, rsp_ch.handle_out);
            fails++;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
            fails++;
          end
          if (rsp_ch.removed_count !== want.removed) begin
            $display("%0t: removed_count expected %0d actual %0d",
                     $time, want.removed, rsp_ch.removed_count);
            fails++;
          end
          if (rsp_ch.busy_at_sweep !== want.busy) begin
            $display("%0t: busy_at_sweep expected %0d actual %0d",
                     $time, want.busy, rsp_ch.busy_at_sweep);
            fails++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready && func_t'(req_ch.func) != FUNC_NONE) begin
        seen_req.func      = func_t'(req_ch.func);
        seen_req.width     = req_ch.width;
        seen_req.height    = req_ch.height;
        seen_req.mode_2d   = req_ch.mode_2d;
        seen_req.format    = req_ch.format;
        seen_req.handle_in = req_ch.handle_in;
        replies_due.insert(replies_due.size(), pool_apply(seen_req));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pool_req_t item;
    int        counted;
    int        acq_weight;
    int        sweep_weight;
    int        roll;
    int        pick;
    clk              = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_ACQUIRE;
    req_ch.width     = '0;
    req_ch.height    = '0;
    req_ch.mode_2d   = 1'b0;
    req_ch.format    = '0;
    req_ch.handle_in = '0;
    rsp_ch.ready     = 1'b0;
    fails            = 0;
    cycle_count      = 0;
    pool_len         = 0;
    acq_weight       = 50;
    sweep_weight     = 6;

    // directed opening
    queue_req(FUNC_ACQUIRE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd0);
    queue_req(FUNC_ACQUIRE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd15);
    queue_req(FUNC_ACQUIRE, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 4'd0);
    queue_req(FUNC_RELEASE, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 4'd0);
    queue_req(FUNC_ACQUIRE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd0);
    queue_req(FUNC_RELEASE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd15);
    queue_req(FUNC_RELEASE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd1);
    queue_req(FUNC_RELEASE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd1);
    queue_req(FUNC_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 4'd15);
    queue_req(FUNC_SWEEP, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd0);
    queue_req(FUNC_SWEEP, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 4'd15);
    for (int i = 0; i < 14; i++)
      queue_req(FUNC_ACQUIRE, 16'(i + 1), 16'h5A5A, i[0], 5'(i), 4'd0);
    queue_req(FUNC_ACQUIRE, 16'h1234, 16'hA5A5, 1'b1, 5'd7, 4'd0);
    queue_req(FUNC_RELEASE, 16'h0000, 16'h0000, 1'b0, 5'd0, 4'd2);
    queue_req(FUNC_ACQUIRE, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 4'd0);

    // random phases over a bank of recurring keys
    for (int b = 0; b < BANK_SIZE; b++) begin
      bank_w[b] = 16'($urandom);
      bank_h[b] = 16'($urandom);
      bank_m[b] = 1'($urandom);
      bank_f[b] = 5'($urandom);
    end
    bank_w[0] = 16'h0000; bank_h[0] = 16'h0000; bank_m[0] = 1'b0; bank_f[0] = 5'd0;
    bank_w[1] = 16'hFFFF; bank_h[1] = 16'hFFFF; bank_m[1] = 1'b1; bank_f[1] = 5'd31;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % PHASE_LEN == 0) begin
        acq_weight   = $urandom_range(30, 75);
        sweep_weight = $urandom_range(2, 12);
        pick         = $urandom_range(2, BANK_SIZE - 1);
        bank_w[pick] = 16'($urandom);
        bank_h[pick] = 16'($urandom);
        bank_m[pick] = 1'($urandom);
        bank_f[pick] = 5'($urandom);
      end
      roll           = $urandom_range(0, 99);
      item.width     = 16'($urandom);
      item.height    = 16'($urandom);
      item.mode_2d   = 1'($urandom);
      item.format    = 5'($urandom);
      item.handle_in = 4'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 15));
      if (roll < 2) begin
        item.func = FUNC_NONE;
      end else if (roll < 2 + sweep_weight) begin
        item.func = FUNC_SWEEP;
      end else if (roll < 2 + sweep_weight + acq_weight) begin
        item.func = FUNC_ACQUIRE;
        if ($urandom_range(0, 99) < 85) begin
          pick         = $urandom_range(0, BANK_SIZE - 1);
          item.width   = bank_w[pick];
          item.height  = bank_h[pick];
          item.mode_2d = bank_m[pick];
          item.format  = bank_f[pick];
        end
      end else begin
        item.func = FUNC_RELEASE;
      end
      pending.insert(pending.size(), item);
      if (item.func != FUNC_NONE) counted++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending.size() != 0 || req_ch.valid || replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
